[rtl/core/pfe_pkg.sv]
// ----------------------------------------------------------------------------
// pfe_pkg
// Shared constants of the pressure floor estimator: field widths, register
// indexes, status codes and the geometry of the digit-serial datapath.
// ----------------------------------------------------------------------------
package pfe_pkg;

    // default number of floors that a sample is matched against
    localparam int PFE_NUM_FLOORS_DEF = 6;

    // field widths
    localparam int PFE_PRESS_W = 24;
    localparam int PFE_FLOOR_W = 8;
    localparam int PFE_SUM_W   = 34;
    localparam int PFE_CNT_W   = 11;
    localparam int PFE_CALI_W  = 10;
    localparam int PFE_STEP_W  = 20;
    localparam int PFE_CFG_W   = 20;
    localparam int PFE_IDX_W   = 2;

    // digit-serial datapath: a word of PFE_W bits moves PFE_DIGW bits a cycle
    localparam int PFE_W     = 36;
    localparam int PFE_DIGW  = 4;
    localparam int PFE_NDIG  = PFE_W / PFE_DIGW;
    localparam int PFE_MACW  = 13;
    localparam int PFE_SEQ_W = $clog2(PFE_W);

    // configuration register indexes
    localparam logic [PFE_IDX_W-1:0] REG_CALI_COUNT = 2'd0;
    localparam logic [PFE_IDX_W-1:0] REG_FLOOR_STEP = 2'd1;
    localparam logic [PFE_IDX_W-1:0] REG_TOLERANCE  = 2'd2;

    // configuration reset values
    localparam logic [PFE_CALI_W-1:0] CALI_COUNT_RST = 10'd100;
    localparam logic [PFE_STEP_W-1:0] FLOOR_STEP_RST = 20'd4000;
    localparam logic [PFE_STEP_W-1:0] TOLERANCE_RST  = 20'd2000;

    // state reset values
    localparam logic [PFE_FLOOR_W-1:0] REF_FLOOR_RST = 8'sd3;

    // result status codes
    localparam logic [1:0] ST_CALIBRATING = 2'd0;
    localparam logic [1:0] ST_CALI_DONE   = 2'd1;
    localparam logic [1:0] ST_MAPPED      = 2'd2;
    localparam logic [1:0] ST_NO_MATCH    = 2'd3;

    // saturation value of the reference pressure
    localparam logic [PFE_PRESS_W-1:0] PRESS_MAX = 24'hFFFFFF;

endpackage

[rtl/core/pressure_floor_estimator.sv]
// ----------------------------------------------------------------------------
// pressure_floor_estimator
// Maps barometric samples to a building floor after averaging a reference.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (valid/ready) carry kind, pressure and known_floor. A kind 1
//   beat recalibrates at known_floor; kind 0 beats are pressure samples.
//   Every input beat yields exactly one output beat (valid/ready) carrying
//   status, floor, calibrated and reference_pressure.
//   Configuration registers are to be written by the user through a plain
//   write port only while the block is idle, which the block does not enforce;
//   they take effect with the next input beat. One beat is processed at a
//   time; the datapath moves 4 bits a cycle over a 36-bit word. Recalibration
//   goes straight to the result; a calibrating sample makes one pass of the
//   sum; calibration finish divides, one quotient bit a cycle; a mapped sample
//   makes a reference pass, then one pass per floor up to NUM_FLOORS floors.
//   The next beat is taken in the cycle after the result is registered.
//   A stalled receiver holds the result in the output register; the block
//   accepts one more beat meanwhile and waits before publishing its result.
//   Reset loads the default registers, clears the calibration and sets the
//   reference floor to 3; the block is ready the cycle after reset.
// ----------------------------------------------------------------------------
module pressure_floor_estimator
    import pfe_pkg::*;
#(
    parameter int NUM_FLOORS = PFE_NUM_FLOORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_we,
    input  logic [PFE_IDX_W-1:0]          i_cfg_index,
    input  logic [PFE_CFG_W-1:0]          i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_kind,
    input  logic [PFE_PRESS_W-1:0]        i_pressure,
    input  logic signed [PFE_FLOOR_W-1:0] i_known_floor,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_status,
    output logic signed [PFE_FLOOR_W-1:0] o_floor,
    output logic                          o_calibrated,
    output logic [PFE_PRESS_W-1:0]        o_reference_pressure
);

    localparam int FLW = $clog2(NUM_FLOORS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_INIT,
        S_FLOOR,
        S_DONE
    } t_state;

    // configuration
    logic [PFE_CALI_W-1:0]          r_cali_count;
    logic [PFE_STEP_W-1:0]          r_floor_step;
    logic [PFE_STEP_W-1:0]          r_tolerance;

    // block state
    logic [PFE_SUM_W-1:0]           r_sum;
    logic [PFE_CNT_W-1:0]           r_count;
    logic                           r_calib;
    logic signed [PFE_FLOOR_W-1:0]  r_ref_floor;
    logic signed [PFE_FLOOR_W-1:0]  r_cur_floor;
    logic [1:0]                     r_status;

    // sequencer
    t_state                         r_state;
    logic [PFE_SEQ_W-1:0]           r_seq;
    logic [FLW-1:0]                 r_fl_idx;

    // digit-serial working registers
    logic [PFE_W-1:0]               r_sh_a;
    logic [PFE_W-1:0]               r_sh_b;
    logic [PFE_W-1:0]               r_sh_c;
    logic signed [PFE_MACW-1:0]     r_mc;
    logic [1:0]                     r_cy;
    logic                           r_ca;
    logic                           r_cb;
    logic                           r_nz;
    logic [PFE_CALI_W-1:0]          r_rem;

    // output register
    logic                           r_out_valid;
    logic [1:0]                     r_out_status;
    logic signed [PFE_FLOOR_W-1:0]  r_out_floor;
    logic                           r_out_calib;
    logic [PFE_PRESS_W-1:0]         r_out_ref;

    // datapath signals
    logic [PFE_DIGW-1:0]            dig_a;
    logic [PFE_DIGW-1:0]            dig_b;
    logic [PFE_DIGW-1:0]            dig_c;
    logic [PFE_CALI_W-1:0]          cnt_eff;
    logic signed [PFE_MACW-1:0]     mul_a;
    logic signed [PFE_MACW-1:0]     mul_b;
    logic signed [PFE_MACW-1:0]     macc;
    logic signed [PFE_MACW-1:0]     n_mc;
    logic [PFE_DIGW+1:0]            init_sum;
    logic [PFE_DIGW:0]              acc_sum;
    logic [PFE_DIGW:0]              fl_diff;
    logic [PFE_DIGW:0]              fl_lo;
    logic [PFE_DIGW:0]              fl_hi;
    logic                           n_nz;
    logic                           fl_match;
    logic [PFE_CALI_W:0]            div_t;
    logic                           div_ge;
    logic [PFE_CALI_W-1:0]          n_rem;
    logic [PFE_W-1:0]               q_full;
    logic [PFE_PRESS_W-1:0]         q_sat;
    logic [PFE_DIGW-1:0]            n_digit;
    logic [PFE_W-1:0]               n_sh_a;
    logic                           last_dig;
    logic                           last_bit;
    logic                           out_free;

    assign o_in_ready           = (r_state == S_IDLE);
    assign o_out_valid          = r_out_valid;
    assign o_status             = r_out_status;
    assign o_floor              = r_out_floor;
    assign o_calibrated         = r_out_calib;
    assign o_reference_pressure = r_out_ref;

    assign out_free = !r_out_valid || i_out_ready;
    assign last_dig = (r_seq == PFE_SEQ_W'(PFE_NDIG - 1));
    assign last_bit = (r_seq == PFE_SEQ_W'(PFE_W - 1));

    // low digits of the shift registers
    assign dig_a = r_sh_a[PFE_DIGW-1:0];
    assign dig_b = r_sh_b[PFE_DIGW-1:0];
    assign dig_c = r_sh_c[PFE_DIGW-1:0];

    // zero count behaves as one
    assign cnt_eff = (r_cali_count == '0) ? PFE_CALI_W'(1) : r_cali_count;

    // digit of floor_step times the signed reference floor, plus carry
    assign mul_a = $signed({{(PFE_MACW - PFE_DIGW){1'b0}}, dig_c});
    assign mul_b = $signed({{(PFE_MACW - PFE_FLOOR_W){r_ref_floor[PFE_FLOOR_W-1]}},
                            r_ref_floor});
    assign macc  = mul_a * mul_b + r_mc;
    assign n_mc  = macc >>> PFE_DIGW;

    // reference - sample + product, one digit
    assign init_sum = {2'b00, dig_a} + {2'b00, macc[PFE_DIGW-1:0]} + {2'b00, ~dig_b}
                    + {{PFE_DIGW{1'b0}}, r_cy};

    // running sum, one digit
    assign acc_sum = {1'b0, dig_a} + {1'b0, dig_b} + {{PFE_DIGW{1'b0}}, r_cy[0]};

    // next floor distance and its two tolerance bounds, one digit
    assign fl_diff = {1'b0, dig_a} + {1'b0, ~dig_c} + {{PFE_DIGW{1'b0}}, r_cy[0]};
    assign fl_lo   = {1'b0, fl_diff[PFE_DIGW-1:0]} + {1'b0, ~dig_b}
                   + {{PFE_DIGW{1'b0}}, r_ca};
    assign fl_hi   = {1'b0, fl_diff[PFE_DIGW-1:0]} + {1'b0, dig_b}
                   + {{PFE_DIGW{1'b0}}, r_cb};
    assign n_nz    = r_nz | (fl_hi[PFE_DIGW-1:0] != '0);
    // distance - tol below zero and distance + tol above zero
    assign fl_match = fl_lo[PFE_DIGW-1] & ~fl_hi[PFE_DIGW-1] & n_nz;

    // restoring division step, one quotient bit
    assign div_t  = {r_rem, r_sh_a[PFE_W-1]};
    assign div_ge = (div_t >= {1'b0, cnt_eff});
    assign n_rem  = div_ge ? PFE_CALI_W'(div_t - {1'b0, cnt_eff})
                           : div_t[PFE_CALI_W-1:0];
    assign q_full = {r_sh_a[PFE_W-2:0], div_ge};
    assign q_sat  = (q_full[PFE_W-1:PFE_PRESS_W] != '0) ? PRESS_MAX
                                                         : q_full[PFE_PRESS_W-1:0];

    // result digit of the running pass
    always_comb begin
        case (r_state)
            S_ACC:   n_digit = acc_sum[PFE_DIGW-1:0];
            S_INIT:  n_digit = init_sum[PFE_DIGW-1:0];
            S_FLOOR: n_digit = fl_diff[PFE_DIGW-1:0];
            default: n_digit = dig_a;
        endcase
    end

    assign n_sh_a = {n_digit, r_sh_a[PFE_W-1:PFE_DIGW]};

    // sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cali_count <= CALI_COUNT_RST;
            r_floor_step <= FLOOR_STEP_RST;
            r_tolerance  <= TOLERANCE_RST;
            r_sum        <= '0;
            r_count      <= '0;
            r_calib      <= 1'b0;
            r_ref_floor  <= REF_FLOOR_RST;
            r_cur_floor  <= '0;
            r_status     <= ST_CALIBRATING;
            r_state      <= S_IDLE;
            r_seq        <= '0;
            r_fl_idx     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_CALI_COUNT: r_cali_count <= i_cfg_data[PFE_CALI_W-1:0];
                    REG_FLOOR_STEP: r_floor_step <= i_cfg_data[PFE_STEP_W-1:0];
                    REG_TOLERANCE:  r_tolerance  <= i_cfg_data[PFE_STEP_W-1:0];
                    default: ;
                endcase
            end

            // output beat taken, publishing handled in the done state
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_seq  <= '0;
                        r_sh_a <= {{(PFE_W - PFE_SUM_W){1'b0}}, r_sum};
                        r_sh_b <= {{(PFE_W - PFE_PRESS_W){1'b0}}, i_pressure};
                        r_sh_c <= {{(PFE_W - PFE_STEP_W){1'b0}}, r_floor_step};
                        r_rem  <= '0;
                        r_mc   <= '0;
                        if (i_kind) begin
                            // recalibrate at the given floor
                            r_ref_floor <= i_known_floor;
                            r_cur_floor <= i_known_floor;
                            r_calib     <= 1'b0;
                            r_sum       <= '0;
                            r_count     <= '0;
                            r_status    <= ST_CALIBRATING;
                            r_state     <= S_DONE;
                        end else if (!r_calib) begin
                            if (r_count < {1'b0, cnt_eff}) begin
                                r_cy    <= 2'd0;
                                r_state <= S_ACC;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end else begin
                            r_cy    <= 2'd1;
                            r_state <= S_INIT;
                        end
                    end
                end

                S_ACC: begin
                    r_sh_a <= n_sh_a;
                    r_sh_b <= {dig_b, r_sh_b[PFE_W-1:PFE_DIGW]};
                    r_cy   <= {1'b0, acc_sum[PFE_DIGW]};
                    r_seq  <= r_seq + 1'b1;
                    if (last_dig) begin
                        r_sum    <= n_sh_a[PFE_SUM_W-1:0];
                        r_count  <= r_count + 1'b1;
                        r_status <= ST_CALIBRATING;
                        r_state  <= S_DONE;
                    end
                end

                S_DIV: begin
                    r_sh_a <= q_full;
                    r_rem  <= n_rem;
                    r_seq  <= r_seq + 1'b1;
                    if (last_bit) begin
                        r_sum    <= {{(PFE_SUM_W - PFE_PRESS_W){1'b0}}, q_sat};
                        r_calib  <= 1'b1;
                        r_status <= ST_CALI_DONE;
                        r_state  <= S_DONE;
                    end
                end

                S_INIT: begin
                    r_sh_a <= n_sh_a;
                    r_sh_c <= {dig_c, r_sh_c[PFE_W-1:PFE_DIGW]};
                    r_mc   <= n_mc;
                    if (last_dig) begin
                        // distance at the reference floor is ready
                        r_sh_b   <= {{(PFE_W - PFE_STEP_W){1'b0}}, r_tolerance};
                        r_seq    <= '0;
                        r_cy     <= 2'd1;
                        r_ca     <= 1'b1;
                        r_cb     <= 1'b0;
                        r_nz     <= 1'b0;
                        r_fl_idx <= FLW'(1);
                        r_state  <= S_FLOOR;
                    end else begin
                        r_sh_b <= {dig_b, r_sh_b[PFE_W-1:PFE_DIGW]};
                        r_cy   <= init_sum[PFE_DIGW+1:PFE_DIGW];
                        r_seq  <= r_seq + 1'b1;
                    end
                end

                S_FLOOR: begin
                    r_sh_a <= n_sh_a;
                    r_sh_b <= {dig_b, r_sh_b[PFE_W-1:PFE_DIGW]};
                    r_sh_c <= {dig_c, r_sh_c[PFE_W-1:PFE_DIGW]};
                    if (last_dig) begin
                        r_seq <= '0;
                        r_cy  <= 2'd1;
                        r_ca  <= 1'b1;
                        r_cb  <= 1'b0;
                        r_nz  <= 1'b0;
                        if (fl_match) begin
                            r_cur_floor <= PFE_FLOOR_W'(r_fl_idx);
                            r_status    <= ST_MAPPED;
                            r_state     <= S_DONE;
                        end else if (r_fl_idx == FLW'(NUM_FLOORS)) begin
                            r_status <= ST_NO_MATCH;
                            r_state  <= S_DONE;
                        end else begin
                            r_fl_idx <= r_fl_idx + 1'b1;
                        end
                    end else begin
                        r_cy  <= {1'b0, fl_diff[PFE_DIGW]};
                        r_ca  <= fl_lo[PFE_DIGW];
                        r_cb  <= fl_hi[PFE_DIGW];
                        r_nz  <= n_nz;
                        r_seq <= r_seq + 1'b1;
                    end
                end

                S_DONE: begin
                    // publish once the output register is free
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_floor  <= r_cur_floor;
                        r_out_calib  <= r_calib;
                        r_out_ref    <= r_calib ? r_sum[PFE_PRESS_W-1:0] : '0;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
